### hdl/atmt_pkg.sv
`default_nettype none

package atmt_pkg;

	localparam int SLOTS = 5;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam int KIND_W     = 2;
	localparam int SLOT_IDX_W = 3;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int FSLOT_W    = 3;
	localparam int COUNT_W    = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_TIME   = 2'd0,
		KIND_SET    = 2'd1,
		KIND_DELETE = 2'd2
	} kind_t;

	typedef struct packed {
		logic take;
		logic clr_res;
		logic note_min;
		logic set_wr;
		logic mark_ign;
		logic scan_init;
		logic shift_init;
		logic step;
		logic hit_rec;
		logic shift_wr;
		logic del_done;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic              item_valid;
		logic [KIND_W-1:0] kind;
		logic              check_due;
		logic              count_zero;
		logic              set_ok;
		logic              del_ok;
		logic              hit;
		logic              at_end;
		logic              out_busy;
		logic [CNT_W-1:0]  count;
	} sts_t;

endpackage

`default_nettype wire

### hdl/atmt_if.sv
`default_nettype none

interface atmt_item_if;
	logic                              valid;
	logic                              ready;
	logic [atmt_pkg::KIND_W-1:0]       kind;
	logic [atmt_pkg::SLOT_IDX_W-1:0]   slot_index;
	logic [atmt_pkg::HOUR_W-1:0]       hour;
	logic [atmt_pkg::MINUTE_W-1:0]     minute;

	modport source (output valid, kind, slot_index, hour, minute, input ready);
	modport sink (input valid, kind, slot_index, hour, minute, output ready);
endinterface

interface atmt_result_if;
	logic                           valid;
	logic                           ready;
	logic                           fired;
	logic [atmt_pkg::FSLOT_W-1:0]   fired_slot;
	logic [atmt_pkg::COUNT_W-1:0]   entry_count;
	logic                           ignored;

	modport source (output valid, fired, fired_slot, entry_count, ignored, input ready);
	modport sink (input valid, fired, fired_slot, entry_count, ignored, output ready);
endinterface

`default_nettype wire

### hdl/atmt_ctrl.sv
`default_nettype none

module atmt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire atmt_pkg::sts_t sts,
	output atmt_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (sts.item_valid) begin
					cmd.clr_res = 1'b1;
					state_next  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_next = ST_FINISH;
				case (atmt_pkg::kind_t'(sts.kind))
					atmt_pkg::KIND_TIME: begin
						if (sts.check_due) begin
							cmd.note_min = 1'b1;
							if (!sts.count_zero) begin
								cmd.scan_init = 1'b1;
								state_next    = ST_SCAN;
							end
						end
					end
					atmt_pkg::KIND_SET: begin
						if (sts.set_ok) begin
							cmd.set_wr = 1'b1;
						end else begin
							cmd.mark_ign = 1'b1;
						end
					end
					atmt_pkg::KIND_DELETE: begin
						if (sts.del_ok) begin
							cmd.shift_init = 1'b1;
							state_next     = ST_SHIFT;
						end else begin
							cmd.mark_ign = 1'b1;
						end
					end
					default: begin
						state_next = ST_FINISH;
					end
				endcase
			end
			ST_SCAN: begin
				if (sts.hit) begin
					cmd.hit_rec = 1'b1;
					state_next  = ST_FINISH;
				end else if (sts.at_end) begin
					state_next = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_SHIFT: begin
				if (sts.at_end) begin
					cmd.del_done = 1'b1;
					state_next   = ST_FINISH;
				end else begin
					cmd.shift_wr = 1'b1;
					cmd.step     = 1'b1;
				end
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

### hdl/atmt_dp.sv
`default_nettype none

module atmt_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	atmt_item_if.sink           item,
	atmt_result_if.source       result,
	input  wire atmt_pkg::cmd_t cmd,
	output atmt_pkg::sts_t      sts
);

	logic [atmt_pkg::KIND_W-1:0]     kind_q;
	logic [atmt_pkg::SLOT_IDX_W-1:0] idx_q;
	logic [atmt_pkg::HOUR_W-1:0]     hour_q;
	logic [atmt_pkg::MINUTE_W-1:0]   minute_q;

	logic                            slot_active_q [atmt_pkg::SLOTS];
	logic [atmt_pkg::HOUR_W-1:0]     slot_hour_q   [atmt_pkg::SLOTS];
	logic [atmt_pkg::MINUTE_W-1:0]   slot_minute_q [atmt_pkg::SLOTS];

	logic [atmt_pkg::CNT_W-1:0]      count_q;
	logic [atmt_pkg::MINUTE_W-1:0]   last_min_q;
	logic                            last_known_q;

	logic [atmt_pkg::IDX_W-1:0]      ptr_q;
	logic                            shift_mode_q;

	logic                            fired_q;
	logic [atmt_pkg::IDX_W-1:0]      fslot_q;
	logic                            ign_q;

	logic                            out_valid_q;
	logic                            out_fired_q;
	logic [atmt_pkg::FSLOT_W-1:0]    out_fslot_q;
	logic [atmt_pkg::COUNT_W-1:0]    out_count_q;
	logic                            out_ign_q;

	logic [atmt_pkg::IDX_W-1:0]      ptr_inc;
	logic [atmt_pkg::IDX_W-1:0]      rd_idx;
	logic [atmt_pkg::IDX_W-1:0]      set_idx;
	logic [atmt_pkg::IDX_W-1:0]      tail_idx;
	logic                            at_end;

	assign item.ready = cmd.take;

	assign ptr_inc  = ptr_q + 1'b1;
	assign at_end   = (int'(ptr_q) + 1) >= int'(count_q);
	assign rd_idx   = (shift_mode_q && !at_end) ? ptr_inc : ptr_q;
	assign set_idx  = atmt_pkg::IDX_W'(idx_q);
	assign tail_idx = atmt_pkg::IDX_W'(count_q - 1'b1);

	always_comb begin
		sts            = '0;
		sts.item_valid = item.valid;
		sts.kind       = kind_q;
		sts.check_due  = !last_known_q || (minute_q != last_min_q);
		sts.count_zero = (count_q == '0);
		sts.set_ok     = int'(idx_q) < atmt_pkg::SLOTS;
		sts.del_ok     = int'(idx_q) < int'(count_q);
		sts.hit        = slot_active_q[rd_idx] && (slot_hour_q[rd_idx] == hour_q) &&
			(slot_minute_q[rd_idx] == minute_q);
		sts.at_end     = at_end;
		sts.out_busy   = out_valid_q && !result.ready;
		sts.count      = count_q;
	end

	always_ff @(posedge clk) begin
		if (item.valid && cmd.take) begin
			kind_q   <= item.kind;
			idx_q    <= item.slot_index;
			hour_q   <= item.hour;
			minute_q <= item.minute;
		end
		if (cmd.scan_init) begin
			ptr_q        <= '0;
			shift_mode_q <= 1'b0;
		end else if (cmd.shift_init) begin
			ptr_q        <= set_idx;
			shift_mode_q <= 1'b1;
		end else if (cmd.step) begin
			ptr_q <= ptr_inc;
		end
		if (cmd.clr_res) begin
			fired_q <= 1'b0;
			fslot_q <= '0;
			ign_q   <= 1'b0;
		end else begin
			if (cmd.hit_rec) begin
				fired_q <= 1'b1;
				fslot_q <= ptr_q;
			end
			if (cmd.mark_ign) begin
				ign_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_fired_q <= fired_q;
			out_fslot_q <= atmt_pkg::FSLOT_W'(fslot_q);
			out_count_q <= atmt_pkg::COUNT_W'(count_q);
			out_ign_q   <= ign_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < atmt_pkg::SLOTS; i++) begin
				slot_active_q[i] <= 1'b0;
				slot_hour_q[i]   <= '0;
				slot_minute_q[i] <= '0;
			end
			count_q      <= '0;
			last_min_q   <= '0;
			last_known_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.note_min) begin
				last_min_q   <= minute_q;
				last_known_q <= 1'b1;
			end
			if (cmd.set_wr) begin
				slot_active_q[set_idx] <= 1'b1;
				slot_hour_q[set_idx]   <= hour_q;
				slot_minute_q[set_idx] <= minute_q;
				if (int'(idx_q) >= int'(count_q)) begin
					count_q <= atmt_pkg::CNT_W'(set_idx) + 1'b1;
				end
			end
			if (cmd.shift_wr) begin
				slot_active_q[ptr_q] <= slot_active_q[rd_idx];
				slot_hour_q[ptr_q]   <= slot_hour_q[rd_idx];
				slot_minute_q[ptr_q] <= slot_minute_q[rd_idx];
			end
			if (cmd.del_done) begin
				count_q                 <= count_q - 1'b1;
				slot_active_q[tail_idx] <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.fired       = out_fired_q;
	assign result.fired_slot  = out_fslot_q;
	assign result.entry_count = out_count_q;
	assign result.ignored     = out_ign_q;

endmodule

`default_nettype wire

### hdl/alarm_time_match_table_unit.sv
// Channel  Role    Beat contents
// item     sink    kind, slot_index, hour, minute
// result   source  fired, fired_slot, entry_count, ignored
//
// A time check for a new minute walks the slots in use one per cycle until the
// first match, and a delete moves the later slots down one per cycle.
// Reset clears the whole table, the slot count and the last checked minute.
// The result sits in an output register; a stalled result holds the unit in
// its final state until that register frees, and the next item beat can be
// taken in the cycle after the result is loaded.

`default_nettype none

module alarm_time_match_table_unit (
	input wire logic      clk,
	input wire logic      arst_n,
	atmt_item_if.sink     item,
	atmt_result_if.source result
);

	atmt_pkg::cmd_t cmd;
	atmt_pkg::sts_t sts;

	atmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	atmt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cmd    (cmd),
		.sts    (sts)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sts.count) <= atmt_pkg::SLOTS)
		else $error("slot count beyond table size");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item taken while another is in progress");

	a_fire_or_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.fired && result.ignored))
		else $error("result both fired and ignored");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(result.valid && !result.ready))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### tb/tb_alarm_time_match_table_unit.sv
`default_nettype none

module tb_alarm_time_match_table_unit;

	localparam logic [atmt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic                         fired;
		logic [atmt_pkg::FSLOT_W-1:0] fired_slot;
		logic [atmt_pkg::COUNT_W-1:0] entry_count;
		logic                         ignored;
	} alarm_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	atmt_item_if   item_ch ();
	atmt_result_if res_ch ();

	alarm_time_match_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	always #10 clk = ~clk;

	// Shadow copy of the alarm table, updated as each item beat is accepted.
	logic                          slot_on [atmt_pkg::SLOTS];
	logic [atmt_pkg::HOUR_W-1:0]   slot_hr [atmt_pkg::SLOTS];
	logic [atmt_pkg::MINUTE_W-1:0] slot_mn [atmt_pkg::SLOTS];
	int                            in_use;
	logic [atmt_pkg::MINUTE_W-1:0] last_minute;
	logic                          minute_seen;

	alarm_outcome_t pending_outcomes [$];
	int             mismatches = 0;
	bit             steady = 1'b0;

	function automatic alarm_outcome_t alarm_table_step(
		input logic [atmt_pkg::KIND_W-1:0] k,
		input logic [atmt_pkg::SLOT_IDX_W-1:0] idx, input logic [atmt_pkg::HOUR_W-1:0] hr,
		input logic [atmt_pkg::MINUTE_W-1:0] mn);
		alarm_outcome_t o;
		int i;
		o = '0;
		case (k)
			atmt_pkg::KIND_TIME: begin
				if (!minute_seen || mn != last_minute) begin
					last_minute = mn;
					minute_seen = 1'b1;
					for (i = 0; i < in_use; i++) begin
						if (slot_on[i] && slot_hr[i] == hr && slot_mn[i] == mn) begin
							o.fired = 1'b1;
							o.fired_slot = 3'(i);
							break;
						end
					end
				end
			end
			atmt_pkg::KIND_SET: begin
				if (idx < atmt_pkg::SLOTS) begin
					slot_on[idx] = 1'b1;
					slot_hr[idx] = hr;
					slot_mn[idx] = mn;
					if (idx >= in_use)
						in_use = idx + 1;
				end else begin
					o.ignored = 1'b1;
				end
			end
			atmt_pkg::KIND_DELETE: begin
				if (idx < in_use) begin
					for (i = idx; i + 1 < in_use; i++) begin
						slot_on[i] = slot_on[i+1];
						slot_hr[i] = slot_hr[i+1];
						slot_mn[i] = slot_mn[i+1];
					end
					in_use--;
					slot_on[in_use] = 1'b0;
				end else begin
					o.ignored = 1'b1;
				end
			end
			default: ;
		endcase
		o.entry_count = 3'(in_use);
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic offer_beat(input logic [atmt_pkg::KIND_W-1:0] k,
		input logic [atmt_pkg::SLOT_IDX_W-1:0] idx,
		input logic [atmt_pkg::HOUR_W-1:0] hr, input logic [atmt_pkg::MINUTE_W-1:0] mn);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_ch.valid      <= 1'b1;
		item_ch.kind       <= k;
		item_ch.slot_index <= idx;
		item_ch.hour       <= hr;
		item_ch.minute     <= mn;
		do @(posedge clk); while (!item_ch.ready);
		pending_outcomes.push_back(alarm_table_step(k, idx, hr, mn));
	endtask

	initial begin
		int hold;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		alarm_outcome_t exp_o;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				exp_o = pending_outcomes.pop_front();
				if (res_ch.fired !== exp_o.fired) begin
					$error("fired: expected %0d, got %0d", exp_o.fired, res_ch.fired);
					mismatches++;
				end
				if (res_ch.fired_slot !== exp_o.fired_slot) begin
					$error("fired_slot: expected %0d, got %0d", exp_o.fired_slot,
						res_ch.fired_slot);
					mismatches++;
				end
				if (res_ch.entry_count !== exp_o.entry_count) begin
					$error("entry_count: expected %0d, got %0d", exp_o.entry_count,
						res_ch.entry_count);
					mismatches++;
				end
				if (res_ch.ignored !== exp_o.ignored) begin
					$error("ignored: expected %0d, got %0d", exp_o.ignored, res_ch.ignored);
					mismatches++;
				end
			end
		end
	end

	task automatic test_time_checks();
		offer_beat(atmt_pkg::KIND_TIME, 3'd0, 5'd0, 6'd0);
		offer_beat(atmt_pkg::KIND_TIME, 3'd7, 5'd31, 6'd0);
		offer_beat(KIND_UNUSED, 3'd7, 5'd31, 6'd63);
	endtask

	task automatic test_slot_writes();
		offer_beat(atmt_pkg::KIND_SET, 3'd0, 5'd23, 6'd59);
		offer_beat(atmt_pkg::KIND_SET, 3'd4, 5'd31, 6'd63);
		offer_beat(atmt_pkg::KIND_SET, 3'd5, 5'd1, 6'd1);
		offer_beat(atmt_pkg::KIND_SET, 3'd7, 5'd2, 6'd2);
		offer_beat(atmt_pkg::KIND_TIME, 3'd0, 5'd0, 6'd0);
		offer_beat(atmt_pkg::KIND_TIME, 3'd0, 5'd23, 6'd59);
		offer_beat(atmt_pkg::KIND_TIME, 3'd0, 5'd23, 6'd59);
		offer_beat(atmt_pkg::KIND_TIME, 3'd0, 5'd31, 6'd63);
		offer_beat(atmt_pkg::KIND_SET, 3'd2, 5'd31, 6'd63);
		offer_beat(atmt_pkg::KIND_TIME, 3'd0, 5'd0, 6'd1);
		offer_beat(atmt_pkg::KIND_TIME, 3'd0, 5'd31, 6'd63);
	endtask

	task automatic test_slot_deletes();
		offer_beat(atmt_pkg::KIND_DELETE, 3'd7, 5'd0, 6'd0);
		offer_beat(atmt_pkg::KIND_DELETE, 3'd5, 5'd0, 6'd0);
		offer_beat(atmt_pkg::KIND_DELETE, 3'd0, 5'd0, 6'd0);
		offer_beat(atmt_pkg::KIND_DELETE, 3'd3, 5'd0, 6'd0);
		offer_beat(atmt_pkg::KIND_SET, 3'd4, 5'd10, 6'd10);
		offer_beat(atmt_pkg::KIND_TIME, 3'd0, 5'd0, 6'd2);
		offer_beat(atmt_pkg::KIND_TIME, 3'd0, 5'd31, 6'd63);
		while (in_use > 0)
			offer_beat(atmt_pkg::KIND_DELETE, 3'd0, 5'd0, 6'd0);
		offer_beat(atmt_pkg::KIND_DELETE, 3'd0, 5'd0, 6'd0);
	endtask

	task automatic test_random_traffic(input int n);
		int r;
		int s;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				if (in_use > 0 && $urandom_range(0, 1)) begin
					s = $urandom_range(0, in_use - 1);
					offer_beat(atmt_pkg::KIND_TIME, 3'($urandom_range(0, 7)), slot_hr[s],
						slot_mn[s]);
				end else begin
					offer_beat(atmt_pkg::KIND_TIME, 3'($urandom_range(0, 7)),
						5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
				end
			end else if (r < 55) begin
				offer_beat(atmt_pkg::KIND_SET, 3'($urandom_range(0, atmt_pkg::SLOTS - 1)),
					5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
			end else if (r < 70) begin
				s = (in_use > 0) ? $urandom_range(0, in_use - 1) : $urandom_range(0, 7);
				offer_beat(atmt_pkg::KIND_DELETE, 3'(s), 5'($urandom_range(0, 31)),
					6'($urandom_range(0, 63)));
			end else if (r < 78) begin
				offer_beat(atmt_pkg::KIND_TIME, 3'($urandom_range(0, 7)),
					5'($urandom_range(0, 31)), last_minute);
			end else begin
				offer_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
					5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
			end
		end
	endtask

	task automatic test_streaming(input int n);
		steady = 1'b1;
		test_random_traffic(n);
		steady = 1'b0;
	endtask

	initial begin
		int i;
		for (i = 0; i < atmt_pkg::SLOTS; i++) begin
			slot_on[i] = 1'b0;
			slot_hr[i] = '0;
			slot_mn[i] = '0;
		end
		in_use = 0;
		last_minute = '0;
		minute_seen = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = atmt_pkg::KIND_TIME;
		item_ch.slot_index = '0;
		item_ch.hour = '0;
		item_ch.minute = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_time_checks();
		test_slot_writes();
		test_slot_deletes();
		test_random_traffic(700);
		test_streaming(150);
		test_random_traffic(250);

		@(negedge clk);
		item_ch.valid <= 1'b0;
		wait (pending_outcomes.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("[alarm_time_match_table_unit] OK");
		end else begin
			$display("[alarm_time_match_table_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[alarm_time_match_table_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
